FILE: rtl/mhd_variable_conversion_assert.svh
// ----------------------------------------------------------------------------
// MHD variable conversion assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef MHD_VARIABLE_CONVERSION_ASSERT_SVH
`define MHD_VARIABLE_CONVERSION_ASSERT_SVH

// same-cycle implication
`define MHD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mhd_vc_pkg.sv
// ----------------------------------------------------------------------------
// MHD variable conversion package
// Shared widths, reset values and codes.
// ----------------------------------------------------------------------------
package mhd_vc_pkg;

   localparam int unsigned FRAC_BITS = 16;
   // dividend of the velocity divide: momentum magnitude scaled up by FRAC_BITS
   localparam int unsigned DIV_W     = 32 + FRAC_BITS;

   localparam int unsigned REQ_W  = 256;
   localparam int unsigned RSP_W  = 128;
   localparam int unsigned CSR_AW = 3;

   localparam logic [17:0] GM1_RESET  = 18'd43691;
   localparam logic [30:0] IGM1_RESET = 31'd98304;

   typedef enum logic {
      REG_GM1  = 1'b0,
      REG_IGM1 = 1'b1
   } reg_idx_type;

   typedef enum logic {
      KIND_TO_PRIM = 1'b0,
      KIND_TO_CONS = 1'b1
   } kind_type;

endpackage

FILE: rtl/mhd_vc_div_lane.sv
// ----------------------------------------------------------------------------
// MHD velocity divider lane
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mhd_vc_div_lane (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [31:0]                   num_mag,
   input  logic [30:0]                   den,
   output logic [mhd_vc_pkg::DIV_W-1:0]  quo
);

   localparam int unsigned W = mhd_vc_pkg::DIV_W;

   logic [30:0]  rem_ff [W];
   logic [30:0]  den_ff [W];
   logic [W-1:0] num_ff [W];
   logic [W-1:0] quo_ff [W];
   logic [30:0]  rem_in [W];
   logic [30:0]  den_in [W];
   logic [W-1:0] num_in [W];
   logic [W-1:0] quo_in [W];

   always_comb begin
      logic [30:0]  rem_p;
      logic [30:0]  den_p;
      logic [W-1:0] num_p;
      logic [W-1:0] quo_p;
      logic [31:0]  trial;
      logic         ge;
      for (int k = 0; k < W; k++) begin
         if (k == 0) begin
            rem_p = '0;
            den_p = den;
            num_p = {num_mag, {mhd_vc_pkg::FRAC_BITS{1'b0}}};
            quo_p = '0;
         end else begin
            rem_p = rem_ff[k-1];
            den_p = den_ff[k-1];
            num_p = num_ff[k-1];
            quo_p = quo_ff[k-1];
         end
         trial     = {rem_p, num_p[W-1]};
         ge        = (trial >= {1'b0, den_p});
         rem_in[k] = ge ? 31'(trial - {1'b0, den_p}) : trial[30:0];
         den_in[k] = den_p;
         num_in[k] = num_p << 1;
         quo_in[k] = {quo_p[W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < W; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            num_ff[k] <= num_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[W-1];

endmodule

FILE: rtl/mhd_variable_conversion.sv
// Pipeline: 57 register stages from the request to the response register.
// Throughput: one request per cycle while the response is not held; the divider (48 stages,
// one quotient bit each) and the nine arithmetic stages after it all advance together.
// Backpressure stalls the whole pipeline in place while the response waits.
// Reset (synchronous, active high) clears all valid bits and loads gamma-1 = 43691
// and 1/(gamma-1) = 98304 (unsigned Q2.16 and Q15.16); no clearing pass is needed.
// ----------------------------------------------------------------------------
// MHD variable conversion
// Conservative <-> primitive ideal-MHD state conversion, one cell per cycle while the response is not held.
// ----------------------------------------------------------------------------
module mhd_variable_conversion (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rho[30:0], in_x, in_y, in_z, mag_x, mag_y, mag_z, in_scalar, one pad bit
   input  logic [mhd_vc_pkg::REQ_W-1:0]      req_tdata,
   // req_type
   input  logic                              req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_z, out_scalar
   output logic [mhd_vc_pkg::RSP_W-1:0]      rsp_tdata,
   // rho_invalid, saturated
   output logic [1:0]                        rsp_tuser,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mhd_vc_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned F       = mhd_vc_pkg::FRAC_BITS;
   localparam int unsigned DW      = mhd_vc_pkg::DIV_W;
   localparam int unsigned V2_W    = 64 - F;          // sum of three squares >> F
   localparam int unsigned V2_LO_W = V2_W / 2;
   localparam int unsigned V2_HI_W = V2_W - V2_LO_W;
   localparam int unsigned RV_W    = 31 + V2_W;       // rho * v^2 before the shift
   localparam int unsigned CAP_W   = 62;              // intermediates clip at 2^62-1
   localparam int unsigned HALF_W  = CAP_W - 1;
   localparam int unsigned SC_W    = 63 - F;          // scalar * inv(gamma-1) >> F
   localparam int unsigned P8_W    = 31 + 18;         // half of |diff| times gamma-1
   localparam int unsigned R2_W    = CAP_W + 18;
   localparam int unsigned CLIP_W  = 128;
   localparam int unsigned NST     = 9;               // stages after the divider

   typedef struct packed {
      mhd_vc_pkg::kind_type  kind;
      logic [30:0]           rho;
      logic [2:0][31:0]      a;
      logic [2:0][31:0]      b;
      logic [31:0]           sc;
   } item_type;

   // travels with a cell once its x/y/z results are settled
   typedef struct packed {
      mhd_vc_pkg::kind_type  kind;
      logic                  inv;
      logic                  sat;
      logic [2:0][31:0]      res;
   } side_type;

   typedef struct packed {
      logic [31:0] val;
      logic [31:0] mag;
      logic        sat;
   } clip_type;

   function automatic logic [31:0] abs32(input logic [31:0] x);
      return x[31] ? 32'(-x) : x;
   endfunction

   // sign-magnitude to signed 32 bits, saturating
   function automatic clip_type clip32(input logic neg, input logic [CLIP_W-1:0] mag);
      clip_type c;
      c.sat = neg ? (mag > CLIP_W'(64'h8000_0000)) : (mag > CLIP_W'(64'h7FFF_FFFF));
      if (c.sat) begin
         c.mag = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         c.mag = mag[31:0];
      end
      c.val = neg ? 32'(-c.mag) : c.mag;
      return c;
   endfunction

   // ---------------------------------------------------------------- config
   logic [17:0] gm_ff;
   logic [30:0] igm_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gm_ff  <= mhd_vc_pkg::GM1_RESET;
         igm_ff <= mhd_vc_pkg::IGM1_RESET;
      end else if (csr_wr) begin
         unique case (mhd_vc_pkg::reg_idx_type'(csr_paddr[2]))
            mhd_vc_pkg::REG_GM1:  gm_ff  <= csr_pwdata[17:0];
            mhd_vc_pkg::REG_IGM1: igm_ff <= csr_pwdata[30:0];
         endcase
      end
   end

   always_comb begin
      unique case (mhd_vc_pkg::reg_idx_type'(csr_paddr[2]))
         mhd_vc_pkg::REG_GM1:  csr_prdata = {14'b0, gm_ff};
         mhd_vc_pkg::REG_IGM1: csr_prdata = {1'b0, igm_ff};
      endcase
   end

   // ---------------------------------------------------------------- flow
   // single pipeline enable: everything moves unless the response is held
   logic adv;
   logic [NST-1:0] pipe_vld_ff;
   logic [DW-1:0]  dvld_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = pipe_vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff     <= '0;
         pipe_vld_ff <= '0;
      end else if (adv) begin
         dvld_ff     <= {dvld_ff[DW-2:0], req_tvalid};
         pipe_vld_ff <= {pipe_vld_ff[NST-2:0], dvld_ff[DW-1]};
      end
   end

   // ---------------------------------------------------------------- divider
   item_type         item_in;
   item_type         dly_ff [DW];
   logic [DW-1:0]    quo [3];

   assign item_in.kind = mhd_vc_pkg::kind_type'(req_tuser);
   assign item_in.rho  = req_tdata[30:0];
   assign item_in.a[0] = req_tdata[62:31];
   assign item_in.a[1] = req_tdata[94:63];
   assign item_in.a[2] = req_tdata[126:95];
   assign item_in.b[0] = req_tdata[158:127];
   assign item_in.b[1] = req_tdata[190:159];
   assign item_in.b[2] = req_tdata[222:191];
   assign item_in.sc   = req_tdata[254:223];

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= item_in;
         for (int k = 1; k < DW; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   // |momentum| << F / rho, one lane per axis
   for (genvar l = 0; l < 3; l++) begin : g_div
      mhd_vc_div_lane u_div (
         .clock   (clock),
         .adv     (adv),
         .num_mag (abs32(item_in.a[l])),
         .den     (item_in.rho),
         .quo     (quo[l])
      );
   end

   // ---------------------------------------------------------------- s1: velocity
   item_type                 d;
   mhd_vc_pkg::kind_type     s1_kind_ff;
   logic                     s1_inv_ff, s1_sat_ff, s1_scneg_ff;
   logic                     s1_inv_in, s1_sat_in;
   logic [30:0]              s1_rho_ff;
   logic [2:0][31:0]         s1_vel_ff, s1_vmag_ff, s1_bmag_ff;
   logic [2:0][31:0]         s1_vel_in, s1_vmag_in;
   logic [2:0]               s1_neg_ff;
   logic [31:0]              s1_sc_ff, s1_scmag_ff;

   assign d = dly_ff[DW-1];

   always_comb begin
      clip_type c;
      s1_inv_in = (d.kind == mhd_vc_pkg::KIND_TO_PRIM) && (d.rho == '0);
      s1_sat_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         c = clip32(d.a[l][31], CLIP_W'(quo[l]));
         if (d.kind == mhd_vc_pkg::KIND_TO_CONS) begin
            s1_vel_in[l]  = d.a[l];
            s1_vmag_in[l] = abs32(d.a[l]);
         end else if (s1_inv_in) begin
            s1_vel_in[l]  = '0;
            s1_vmag_in[l] = '0;
         end else begin
            s1_vel_in[l]  = c.val;
            s1_vmag_in[l] = c.mag;
            s1_sat_in     = s1_sat_in | c.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff  <= d.kind;
         s1_inv_ff   <= s1_inv_in;
         s1_sat_ff   <= s1_sat_in;
         s1_rho_ff   <= d.rho;
         s1_vel_ff   <= s1_vel_in;
         s1_vmag_ff  <= s1_vmag_in;
         for (int l = 0; l < 3; l++) begin
            s1_neg_ff[l]  <= d.a[l][31];
            s1_bmag_ff[l] <= abs32(d.b[l]);
         end
         s1_sc_ff    <= d.sc;
         s1_scneg_ff <= d.sc[31];
         s1_scmag_ff <= abs32(d.sc);
      end
   end

   // ---------------------------------------------------------------- s2: products
   mhd_vc_pkg::kind_type     s2_kind_ff;
   logic                     s2_inv_ff, s2_sat_ff, s2_scneg_ff;
   logic [2:0][31:0]         s2_vel_ff;
   logic [2:0]               s2_neg_ff;
   logic [30:0]              s2_rho_ff;
   logic [31:0]              s2_sc_ff;
   logic [2:0][63:0]         s2_sqv_ff, s2_sqb_ff;
   logic [2:0][62:0]         s2_momp_ff;
   logic [62:0]              s2_scp_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_inv_ff   <= s1_inv_ff;
         s2_sat_ff   <= s1_sat_ff;
         s2_vel_ff   <= s1_vel_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_rho_ff   <= s1_rho_ff;
         s2_sc_ff    <= s1_sc_ff;
         s2_scneg_ff <= s1_scneg_ff;
         for (int l = 0; l < 3; l++) begin
            s2_sqv_ff[l]  <= 64'(s1_vmag_ff[l]) * 64'(s1_vmag_ff[l]);
            s2_sqb_ff[l]  <= 64'(s1_bmag_ff[l]) * 64'(s1_bmag_ff[l]);
            s2_momp_ff[l] <= 63'(s1_vmag_ff[l]) * 63'(s1_rho_ff);
         end
         s2_scp_ff   <= 63'(s1_scmag_ff) * 63'(igm_ff);
      end
   end

   // ---------------------------------------------------------------- s3: sums, momentum
   side_type                 s3_side_ff, s3_side_in;
   logic [30:0]              s3_rho_ff;
   logic [31:0]              s3_sc_ff;
   logic                     s3_scneg_ff;
   logic [SC_W-1:0]          s3_sct_ff;
   logic [V2_W-1:0]          s3_v2_ff, s3_b2_ff, s3_v2_in, s3_b2_in;

   always_comb begin
      clip_type c;
      s3_side_in.kind = s2_kind_ff;
      s3_side_in.inv  = s2_inv_ff;
      s3_side_in.sat  = s2_sat_ff;
      s3_v2_in        = '0;
      s3_b2_in        = '0;
      for (int l = 0; l < 3; l++) begin
         s3_v2_in = s3_v2_in + V2_W'(s2_sqv_ff[l] >> F);
         s3_b2_in = s3_b2_in + V2_W'(s2_sqb_ff[l] >> F);
         c = clip32(s2_neg_ff[l], CLIP_W'(s2_momp_ff[l] >> F));
         if (s2_kind_ff == mhd_vc_pkg::KIND_TO_CONS) begin
            s3_side_in.res[l] = c.val;
            s3_side_in.sat    = s3_side_in.sat | c.sat;
         end else begin
            s3_side_in.res[l] = s2_vel_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_side_ff  <= s3_side_in;
         s3_rho_ff   <= s2_rho_ff;
         s3_sc_ff    <= s2_sc_ff;
         s3_scneg_ff <= s2_scneg_ff;
         s3_sct_ff   <= SC_W'(s2_scp_ff >> F);
         s3_v2_ff    <= s3_v2_in;
         s3_b2_ff    <= s3_b2_in;
      end
   end

   // ---------------------------------------------------------------- s4: rho * v^2 halves
   side_type                 s4_side_ff;
   logic [31:0]              s4_sc_ff;
   logic                     s4_scneg_ff;
   logic [SC_W-1:0]          s4_sct_ff;
   logic [V2_W-1:0]          s4_b2_ff;
   logic [31+V2_LO_W-1:0]    s4_pl_ff;
   logic [31+V2_HI_W-1:0]    s4_ph_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff  <= s3_side_ff;
         s4_sc_ff    <= s3_sc_ff;
         s4_scneg_ff <= s3_scneg_ff;
         s4_sct_ff   <= s3_sct_ff;
         s4_b2_ff    <= s3_b2_ff;
         s4_pl_ff    <= (31+V2_LO_W)'(s3_rho_ff) * (31+V2_LO_W)'(s3_v2_ff[V2_LO_W-1:0]);
         s4_ph_ff    <= (31+V2_HI_W)'(s3_rho_ff) * (31+V2_HI_W)'(s3_v2_ff[V2_W-1:V2_LO_W]);
      end
   end

   // ---------------------------------------------------------------- s5: combine, clip
   side_type                 s5_side_ff, s5_side_in;
   logic [31:0]              s5_sc_ff;
   logic                     s5_scneg_ff;
   logic [SC_W-1:0]          s5_sct_ff;
   logic [V2_W-1:0]          s5_b2_ff;
   logic [CAP_W-1:0]         s5_rv_ff, s5_rv_in;

   always_comb begin
      logic [RV_W-1:0] rv_sh;
      rv_sh      = ((RV_W'(s4_ph_ff) << V2_LO_W) + RV_W'(s4_pl_ff)) >> F;
      s5_side_in = s4_side_ff;
      if (rv_sh > RV_W'({CAP_W{1'b1}})) begin
         s5_rv_in       = {CAP_W{1'b1}};
         s5_side_in.sat = 1'b1;
      end else begin
         s5_rv_in = rv_sh[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_side_ff  <= s5_side_in;
         s5_sc_ff    <= s4_sc_ff;
         s5_scneg_ff <= s4_scneg_ff;
         s5_sct_ff   <= s4_sct_ff;
         s5_b2_ff    <= s4_b2_ff;
         s5_rv_ff    <= s5_rv_in;
      end
   end

   // ---------------------------------------------------------------- s6: (rho v^2 + B^2) / 2
   side_type                 s6_side_ff, s6_side_in;
   logic [31:0]              s6_sc_ff;
   logic                     s6_scneg_ff;
   logic [SC_W-1:0]          s6_sct_ff;
   logic [HALF_W-1:0]        s6_half_ff, s6_half_in;

   always_comb begin
      logic [CAP_W:0] ssum;
      ssum       = {1'b0, s5_rv_ff} + (CAP_W+1)'(s5_b2_ff);
      s6_side_in = s5_side_ff;
      if (ssum[CAP_W]) begin
         s6_half_in     = {HALF_W{1'b1}};
         s6_side_in.sat = 1'b1;
      end else begin
         s6_half_in = ssum[CAP_W-1:1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_side_ff  <= s6_side_in;
         s6_sc_ff    <= s5_sc_ff;
         s6_scneg_ff <= s5_scneg_ff;
         s6_sct_ff   <= s5_sct_ff;
         s6_half_ff  <= s6_half_in;
      end
   end

   // ---------------------------------------------------------------- s7: energy terms
   // to primitive: E - half, scaled next; to conservative: p*inv(gamma-1) + half
   side_type                 s7_side_ff, s7_side_in;
   logic [CAP_W-1:0]         s7_dmag_ff, s7_dmag_in;
   logic                     s7_dneg_ff, s7_dneg_in;
   logic [31:0]              s7_t1_ff;
   clip_type                 t1c;

   always_comb begin
      logic [CAP_W:0] diff;
      logic [CAP_W:0] tsum;
      logic [CAP_W:0] tterm;
      diff       = (CAP_W+1)'($signed(s6_sc_ff)) - (CAP_W+1)'(s6_half_ff);
      s7_dneg_in = diff[CAP_W];
      s7_dmag_in = s7_dneg_in ? CAP_W'(-diff) : diff[CAP_W-1:0];
      tterm      = s6_scneg_ff ? (CAP_W+1)'(-(CAP_W+1)'(s6_sct_ff)) : (CAP_W+1)'(s6_sct_ff);
      tsum       = tterm + (CAP_W+1)'(s6_half_ff);
      t1c        = clip32(tsum[CAP_W],
                          CLIP_W'(tsum[CAP_W] ? CAP_W'(-tsum) : tsum[CAP_W-1:0]));
      s7_side_in = s6_side_ff;
      if (s6_side_ff.kind == mhd_vc_pkg::KIND_TO_CONS) begin
         s7_side_in.sat = s6_side_ff.sat | t1c.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_side_ff <= s7_side_in;
         s7_dmag_ff <= s7_dmag_in;
         s7_dneg_ff <= s7_dneg_in;
         s7_t1_ff   <= t1c.val;
      end
   end

   // ---------------------------------------------------------------- s8: times gamma-1
   side_type                 s8_side_ff;
   logic                     s8_dneg_ff;
   logic [31:0]              s8_t1_ff;
   logic [P8_W-1:0]          s8_plo_ff, s8_phi_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_side_ff <= s7_side_ff;
         s8_dneg_ff <= s7_dneg_ff;
         s8_t1_ff   <= s7_t1_ff;
         s8_plo_ff  <= P8_W'(s7_dmag_ff[30:0]) * P8_W'(gm_ff);
         s8_phi_ff  <= P8_W'(s7_dmag_ff[CAP_W-1:31]) * P8_W'(gm_ff);
      end
   end

   // ---------------------------------------------------------------- s9: response register
   logic [mhd_vc_pkg::RSP_W-1:0] rsp_tdata_ff;
   logic [1:0]                   rsp_tuser_ff;
   clip_type                     pc;
   logic [31:0]                  scal;
   logic                         sat9;

   always_comb begin
      logic [R2_W-1:0] r2;
      r2 = ((R2_W'(s8_phi_ff) << 31) + R2_W'(s8_plo_ff)) >> F;
      pc = clip32(s8_dneg_ff, CLIP_W'(r2));
      if (s8_side_ff.kind == mhd_vc_pkg::KIND_TO_PRIM) begin
         scal = pc.val;
         sat9 = s8_side_ff.sat | pc.sat;
      end else begin
         scal = s8_t1_ff;
         sat9 = s8_side_ff.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {scal, s8_side_ff.res[2], s8_side_ff.res[1], s8_side_ff.res[0]};
         rsp_tuser_ff <= {sat9, s8_side_ff.inv};
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   // ---------------------------------------------------------------- checks
`include "mhd_variable_conversion_assert.svh"

   `MHD_ASSERT_SAME(a_held_rsp_blocks_req, rsp_tvalid && !rsp_tready, !req_tready, "request taken while response held")
   `MHD_ASSERT_SAME(a_bad_rho_zero_vel, rsp_tvalid && rsp_tuser[0], rsp_tdata[95:0] == '0, "velocity not zero for bad density")
   `MHD_ASSERT_NEXT(a_stall_freezes_pipe, rsp_tvalid && !rsp_tready, (pipe_vld_ff == $past(pipe_vld_ff)) && (dvld_ff == $past(dvld_ff)), "pipeline moved during stall")

endmodule

FILE: tb/mhd_variable_conversion_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MHD variable conversion testbench
// Drives cells in both directions through the request stream, predicts each
// response with an independent fixed-point model, and compares field by field.
// ----------------------------------------------------------------------------
module mhd_variable_conversion_test;

   localparam longint unsigned CAP62   = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam int              LATENCY = 60;
   localparam int              WATCHDOG_LIMIT = 20000;
   localparam int              N_RANDOM = 1200;

   typedef struct packed {
      logic        kind;
      logic [30:0] rho;
      logic [31:0] mx, my, mz, bx, by, bz, scal;
   } cell_type;

   typedef struct packed {
      logic [31:0] ox, oy, oz, oscal;
      logic        rho_bad;
      logic        clipped;
   } conv_type;

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [mhd_vc_pkg::REQ_W-1:0] req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [mhd_vc_pkg::RSP_W-1:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel, csr_penable, csr_pwrite;
   logic [mhd_vc_pkg::CSR_AW-1:0] csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;
   logic         csr_pready;

   mhd_variable_conversion dut (.*);

   // predictor copy of the registers
   logic [17:0] gm1_q;
   logic [30:0] igm1_q;

   conv_type pending_convs[$];
   int       fail_count;
   int       idle_cycles;
   bit       hold_rsp;
   bit       stim_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic longint unsigned mag_of(longint signed x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   // (a*b) >> FRAC_BITS on magnitudes, clipped at 2^62-1
   function automatic longint unsigned mul_frac(longint unsigned a, longint unsigned b,
                                                ref bit clip);
      logic [127:0] p;
      p = (128'(a) * 128'(b)) >> mhd_vc_pkg::FRAC_BITS;
      if (p > 128'(CAP62)) begin
         clip = 1'b1;
         return CAP62;
      end
      return p[63:0];
   endfunction

   function automatic longint signed mul_frac_s(longint signed a, longint unsigned b,
                                                ref bit clip);
      longint unsigned m;
      m = mul_frac(mag_of(a), b, clip);
      return (a < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint signed clip32(longint signed x, ref bit clip);
      if (x > 64'sd2147483647) begin
         clip = 1'b1;
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         clip = 1'b1;
         return -64'sd2147483648;
      end
      return x;
   endfunction

   // half of (rho*v^2 + B^2)
   function automatic longint unsigned half_energy(longint unsigned rho,
         longint signed v[3], longint signed b[3], ref bit clip);
      longint unsigned v2, b2, s;
      v2 = 0;
      b2 = 0;
      for (int i = 0; i < 3; i++) begin
         v2 += mul_frac(mag_of(v[i]), mag_of(v[i]), clip);
         b2 += mul_frac(mag_of(b[i]), mag_of(b[i]), clip);
      end
      s = mul_frac(rho, v2, clip) + b2;
      if (s > CAP62) begin
         clip = 1'b1;
         s = CAP62;
      end
      return s >> 1;
   endfunction

   function automatic conv_type convert_cell(cell_type c);
      conv_type r;
      bit clip;
      longint signed a[3], b[3], v[3], res[3], scal, outs;
      longint unsigned rho, q;
      clip = 1'b0;
      rho = 64'(c.rho);
      a[0] = signed'(c.mx); a[1] = signed'(c.my); a[2] = signed'(c.mz);
      b[0] = signed'(c.bx); b[1] = signed'(c.by); b[2] = signed'(c.bz);
      scal = signed'(c.scal);
      r.rho_bad = 1'b0;
      if (c.kind == mhd_vc_pkg::KIND_TO_PRIM) begin
         for (int i = 0; i < 3; i++) begin
            if (rho == 0) begin
               v[i] = 0;
            end else begin
               q = (mag_of(a[i]) << mhd_vc_pkg::FRAC_BITS) / rho;
               v[i] = clip32((a[i] < 0) ? -longint'(q) : longint'(q), clip);
            end
            res[i] = v[i];
         end
         r.rho_bad = (rho == 0);
         outs = clip32(mul_frac_s(scal - longint'(half_energy(rho, v, b, clip)),
                                  64'(gm1_q), clip), clip);
      end else begin
         for (int i = 0; i < 3; i++)
            res[i] = clip32(mul_frac_s(a[i], rho, clip), clip);
         outs = mul_frac_s(scal, 64'(igm1_q), clip);
         outs = clip32(outs + longint'(half_energy(rho, a, b, clip)), clip);
      end
      r.ox = res[0][31:0];
      r.oy = res[1][31:0];
      r.oz = res[2][31:0];
      r.oscal = outs[31:0];
      r.clipped = clip;
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic csr_write(mhd_vc_pkg::reg_idx_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= mhd_vc_pkg::CSR_AW'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == mhd_vc_pkg::REG_GM1) gm1_q = value[17:0];
      else igm1_q = value[30:0];
   endtask

   // optional random gap, then one request held until taken
   task automatic send_cell(cell_type c, bit allow_gap);
      int gap;
      gap = 0;
      if (allow_gap && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.kind;
      req_tdata  <= mhd_vc_pkg::REQ_W'({c.scal, c.bz, c.by, c.bx, c.mz, c.my, c.mx, c.rho});
      do @(posedge clock); while (!req_tready);
      pending_convs.push_back(convert_cell(c));
   endtask

   // wait for the pipe to empty, then let it settle
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_convs.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word(int mode);
      case (mode)
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic cell_type rand_cell;
      cell_type c;
      int span;
      span = $urandom_range(0, 9);
      c.kind = 1'($urandom);
      case ($urandom_range(0, 9))
         0: c.rho = '0;
         1: c.rho = 31'h7FFF_FFFF;
         2, 3: c.rho = 31'($urandom);
         default: c.rho = 31'($urandom_range(1, 32'h0004_0000));
      endcase
      // mostly modest values so results rarely clip
      c.mx = rand_word(span < 7 ? 2 : $urandom_range(0, 3));
      c.my = rand_word(span < 7 ? 2 : $urandom_range(0, 3));
      c.mz = rand_word(span < 7 ? 2 : $urandom_range(0, 3));
      c.bx = rand_word(span < 7 ? 2 : $urandom_range(0, 3));
      c.by = rand_word(span < 7 ? 2 : $urandom_range(0, 3));
      c.bz = rand_word(span < 7 ? 2 : $urandom_range(0, 3));
      c.scal = rand_word(span < 7 ? 2 : $urandom_range(0, 3));
      return c;
   endfunction

   // ---------------------------------------------------------------- directed
   typedef struct {
      cell_type stim;
      bit       known;
      conv_type resp;
   } row_type;

   localparam int N_ROWS = 10;
   row_type dir_rows[N_ROWS];

   initial begin
      // zero cell, both directions
      dir_rows[0] = '{'{mhd_vc_pkg::KIND_TO_PRIM, 31'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        32'd0, 32'd0, 32'd0}, 1,
                      '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0}};
      dir_rows[1] = '{'{mhd_vc_pkg::KIND_TO_CONS, 31'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                        32'd0, 32'd0, 32'd0}, 1,
                      '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}};
      // unit density, unit momentum: velocity 1.0
      dir_rows[2] = '{'{mhd_vc_pkg::KIND_TO_PRIM, 31'h10000, 32'h10000, 32'hFFFF0000,
                        32'd0, 32'd0, 32'd0, 32'd0, 32'h30000}, 0, '{default: '0}};
      // zero density with field: velocity forced to zero, flagged
      dir_rows[3] = '{'{mhd_vc_pkg::KIND_TO_PRIM, 31'd0, 32'h7FFFFFFF, 32'h80000000,
                        32'h12345, 32'h20000, 32'hFFFE0000, 32'h10000, 32'h50000}, 0,
                      '{default: '0}};
      // largest density and momenta: unit velocity, clipped pressure
      dir_rows[4] = '{'{mhd_vc_pkg::KIND_TO_PRIM, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                        32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        32'h80000000}, 0, '{default: '0}};
      dir_rows[5] = '{'{mhd_vc_pkg::KIND_TO_PRIM, 31'd1, 32'h7FFFFFFF, 32'h80000000, 32'd1,
                        32'd0, 32'd0, 32'd0, 32'h7FFFFFFF}, 0, '{default: '0}};
      // zero density in prim->cons is valid
      dir_rows[6] = '{'{mhd_vc_pkg::KIND_TO_CONS, 31'd0, 32'h7FFFFFFF, 32'h80000000,
                        32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000}, 0,
                      '{default: '0}};
      dir_rows[7] = '{'{mhd_vc_pkg::KIND_TO_CONS, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                        32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        32'h7FFFFFFF}, 0, '{default: '0}};
      dir_rows[8] = '{'{mhd_vc_pkg::KIND_TO_CONS, 31'h20000, 32'h18000, 32'hFFFF8000,
                        32'h4000, 32'hFFFF0000, 32'h8000, 32'h0, 32'h80000000}, 0,
                      '{default: '0}};
      dir_rows[9] = '{'{mhd_vc_pkg::KIND_TO_PRIM, 31'h8000, 32'hFFFFFFFF, 32'h1, 32'hFFFF,
                        32'hFFFF, 32'hFFFF0001, 32'h1, 32'h1}, 0, '{default: '0}};
   end

   // ---------------------------------------------------------------- main flow
   initial begin
      logic [17:0] gm1_set[4];
      logic [30:0] igm1_set[4];
      fail_count  = 0;
      stim_done   = 1'b0;
      hold_rsp    = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      gm1_q  = mhd_vc_pkg::GM1_RESET;
      igm1_q = mhd_vc_pkg::IGM1_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the registers first
      foreach (dir_rows[i]) begin
         send_cell(dir_rows[i].stim, 1'b0);
         if (dir_rows[i].known) begin
            void'(pending_convs.pop_back());
            pending_convs.push_back(dir_rows[i].resp);
         end
      end
      drain();

      // extremes and typical settings; second phase also stalls the receiver
      gm1_set  = '{18'd1, 18'h3FFFF, 18'd131072, 18'd26214};
      igm1_set = '{31'h7FFFFFFF, 31'd32768, 31'd0, 31'd163840};
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(mhd_vc_pkg::REG_GM1, 32'(gm1_set[ph]));
         csr_write(mhd_vc_pkg::REG_IGM1, 32'(igm1_set[ph]));
         foreach (dir_rows[i]) send_cell(dir_rows[i].stim, 1'b1);
         for (int n = 0; n < N_RANDOM / 4; n++) begin
            if (ph == 1 && n == 40) hold_rsp = 1'b1;
            send_cell(rand_cell(), 1'b1);
         end
         drain();
      end
      stim_done = 1'b1;
      if (fail_count == 0 && pending_convs.size() == 0)
         $display("PASS mhd_variable_conversion");
      else
         $display("FAIL mhd_variable_conversion");
      $finish;
   end

   // ---------------------------------------------------------------- receiver
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            // long hold-off so the pipe fills and backs up the request side
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if ($urandom_range(0, 3) == 0) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                : $urandom_range(1, 3);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // compare responses with the oldest expectation
   always @(posedge clock) begin
      conv_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ox      = rsp_tdata[31:0];
         got.oy      = rsp_tdata[63:32];
         got.oz      = rsp_tdata[95:64];
         got.oscal   = rsp_tdata[127:96];
         got.rho_bad = rsp_tuser[0];
         got.clipped = rsp_tuser[1];
         if (pending_convs.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_convs.pop_front();
            if (got.ox !== want.ox) begin
               $error("out_x exp %h got %h", want.ox, got.ox); fail_count++;
            end
            if (got.oy !== want.oy) begin
               $error("out_y exp %h got %h", want.oy, got.oy); fail_count++;
            end
            if (got.oz !== want.oz) begin
               $error("out_z exp %h got %h", want.oz, got.oz); fail_count++;
            end
            if (got.oscal !== want.oscal) begin
               $error("out_scalar exp %h got %h", want.oscal, got.oscal); fail_count++;
            end
            if (got.rho_bad !== want.rho_bad) begin
               $error("rho_invalid exp %b got %b", want.rho_bad, got.rho_bad);
               fail_count++;
            end
            if (got.clipped !== want.clipped) begin
               $error("saturated exp %b got %b", want.clipped, got.clipped);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either channel and no config access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
         $display("FAIL mhd_variable_conversion");
         $finish;
      end
   end

endmodule
